>>> rtl/cbta_pkg.sv
// Shared types, codes and constants of the chained block table allocator.
package cbta_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int RESERVED_DEF   = 5;

  // Field widths fixed by the interface.
  localparam int BLK_W    = 16;
  localparam int CNT_W    = 13;
  localparam int UPD_W    = 16;
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 48;
  localparam int CFG_IDX_W = 1;

  localparam logic [BLK_W-1:0] END_MARK    = 16'hFFFF;
  localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CARD  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOCARD   = 2'd1,
    ST_INSSPACE = 2'd2,
    ST_BROKEN   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC_RUN,
    S_TAIL_OK,
    S_TAIL_BAD,
    S_FREE_STEP,
    S_FREE_WAIT,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear_step;
    logic    load;
    logic    alloc_begin;
    logic    alloc_step;
    logic    tail_write;
    logic    tail_ok;
    logic    free_issue;
    logic    free_retire;
    logic    set_res;
    status_t res_code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic no_card;
    logic is_free;
    logic short_space;
    logic want_zero;
    logic limit_zero;
    logic alloc_done;
    logic alloc_broken;
    logic walk_end;
    logic walk_bad;
  } dp_stat_t;

endpackage

>>> rtl/cbta_datapath.sv
// Datapath of the allocator: link table memory, counters, walk registers and results.
module cbta_datapath #(
  parameter int MAX_BLOCKS      = cbta_pkg::MAX_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = cbta_pkg::RESERVED_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cbta_pkg::dp_cmd_t                  cmd,
  output cbta_pkg::dp_stat_t                 stat,
  input  logic                               cfg_we,
  input  logic [cbta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbta_pkg::CNT_W-1:0]         cfg_wdata,
  input  cbta_pkg::cmd_t                     in_cmd,
  input  logic [cbta_pkg::CNT_W-1:0]         in_count,
  input  logic [cbta_pkg::BLK_W-1:0]         in_start,
  output cbta_pkg::status_t                  res_status,
  output logic [cbta_pkg::BLK_W-1:0]         res_first,
  output logic [cbta_pkg::CNT_W-1:0]         res_free,
  output logic [cbta_pkg::UPD_W-1:0]         res_update
);

  localparam int ADDR_W = $clog2(MAX_BLOCKS);
  localparam int BLK_W  = cbta_pkg::BLK_W;
  localparam int CNT_W  = cbta_pkg::CNT_W;

  // Link table and its registered read port.
  logic [BLK_W-1:0]  mem [MAX_BLOCKS];
  logic [BLK_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BLK_W-1:0]  wdata;

  // Configuration and persistent state.
  logic [CNT_W-1:0]  total_blocks;
  logic              card_present;
  logic [CNT_W-1:0]  free_blocks;
  logic [ADDR_W-1:0] hint;
  logic [cbta_pkg::UPD_W-1:0] update_counter;
  logic [ADDR_W-1:0] clr_addr;

  // Command registers.
  cbta_pkg::cmd_t    cmd_r;
  logic [CNT_W-1:0]  want;
  logic [BLK_W-1:0]  walk_blk;

  // Allocation probe pipeline.
  logic [ADDR_W-1:0] iss_blk;
  logic [CNT_W-1:0]  iss_probes;
  logic              chk_v;
  logic [ADDR_W-1:0] chk_blk;
  logic              chk_last;
  logic              start_found;
  logic [ADDR_W-1:0] start_blk;
  logic [ADDR_W-1:0] prev_blk;

  logic [CNT_W-1:0]  eff_total;
  logic [CNT_W-1:0]  limit;
  logic [BLK_W-1:0]  nxt_wide;
  logic [ADDR_W-1:0] nxt_blk;
  logic              issue;
  logic              hit;

  function automatic logic blk_valid(input logic [BLK_W-1:0] b,
                                     input logic [CNT_W-1:0] tot);
    blk_valid = (b >= BLK_W'(RESERVED_BLOCKS)) && (b < BLK_W'(tot));
  endfunction

  // Effective block count and probe limit.
  assign eff_total = (total_blocks > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_blocks;
  assign limit     = (eff_total > CNT_W'(RESERVED_BLOCKS)) ?
                     CNT_W'(eff_total - CNT_W'(RESERVED_BLOCKS)) : '0;

  // Next candidate block, wrapping back to the first unreserved block.
  assign nxt_wide = BLK_W'(iss_blk) + BLK_W'(1);
  assign nxt_blk  = blk_valid(nxt_wide, eff_total) ? nxt_wide[ADDR_W-1:0] :
                    ADDR_W'(RESERVED_BLOCKS);
  assign issue    = cmd.alloc_step && (iss_probes < limit);
  assign hit      = chk_v && (rd_data == '0);

  // Status towards the controller.
  always_comb begin
    stat.clear_done   = (clr_addr == ADDR_W'(MAX_BLOCKS - 1));
    stat.no_card      = !card_present;
    stat.is_free      = (cmd_r == cbta_pkg::CMD_FREE);
    stat.short_space  = (free_blocks < want);
    stat.want_zero    = (want == '0);
    stat.limit_zero   = (limit == '0);
    stat.alloc_done   = hit && (want == CNT_W'(1));
    stat.alloc_broken = chk_v && chk_last && !(hit && (want == CNT_W'(1)));
    stat.walk_end     = (walk_blk == cbta_pkg::END_MARK);
    stat.walk_bad     = !blk_valid(walk_blk, eff_total);
  end

  // Write port selection.
  always_comb begin
    we    = 1'b0;
    waddr = prev_blk;
    wdata = '0;
    if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (cmd.alloc_step && hit && start_found) begin
      we    = 1'b1;
      wdata = BLK_W'(chk_blk);
    end else if (cmd.tail_write && start_found) begin
      we    = 1'b1;
      wdata = cbta_pkg::END_MARK;
    end else if (cmd.free_retire) begin
      we    = 1'b1;
      waddr = walk_blk[ADDR_W-1:0];
    end
  end

  assign rd_addr = cmd.free_issue ? walk_blk[ADDR_W-1:0] : nxt_blk;

  // Link table memory.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Control and persistent state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks   <= cbta_pkg::TOTAL_RESET;
      card_present   <= 1'b1;
      free_blocks    <= CNT_W'(MAX_BLOCKS - RESERVED_BLOCKS);
      hint           <= ADDR_W'(RESERVED_BLOCKS - 1);
      update_counter <= '0;
      clr_addr       <= '0;
      chk_v          <= 1'b0;
      start_found    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cbta_pkg::CFG_TOTAL: total_blocks <= cfg_wdata;
          cbta_pkg::CFG_CARD:  card_present <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.clear_step && !stat.clear_done) begin
        clr_addr <= ADDR_W'(clr_addr + ADDR_W'(1));
      end
      if (cmd.alloc_begin) begin
        free_blocks <= CNT_W'(free_blocks - want);
        chk_v       <= 1'b0;
        start_found <= 1'b0;
      end
      if (cmd.alloc_step) begin
        chk_v <= issue;
        if (hit) begin
          start_found <= 1'b1;
        end
      end
      if (cmd.tail_ok) begin
        hint <= prev_blk;
      end
      if (cmd.free_retire && (free_blocks != '1)) begin
        free_blocks <= CNT_W'(free_blocks + CNT_W'(1));
      end
      if (cmd.set_res && (cmd.res_code == cbta_pkg::ST_OK)) begin
        update_counter <= cbta_pkg::UPD_W'(update_counter + cbta_pkg::UPD_W'(1));
      end
    end
  end

  // Payload registers of the command in progress.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      want     <= in_count;
      walk_blk <= in_start;
    end
    if (cmd.alloc_begin) begin
      iss_blk    <= hint;
      iss_probes <= '0;
    end
    if (issue) begin
      iss_blk    <= nxt_blk;
      iss_probes <= CNT_W'(iss_probes + CNT_W'(1));
      chk_blk    <= nxt_blk;
      chk_last   <= (CNT_W'(iss_probes + CNT_W'(1)) == limit);
    end
    if (cmd.alloc_step && hit) begin
      want     <= CNT_W'(want - CNT_W'(1));
      prev_blk <= chk_blk;
      if (!start_found) begin
        start_blk <= chk_blk;
      end
    end
    if (cmd.free_retire) begin
      walk_blk <= rd_data;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_first  <= cmd.tail_ok ? BLK_W'(start_blk) : cbta_pkg::END_MARK;
    end
  end

  assign res_free   = free_blocks;
  assign res_update = update_counter;

endmodule

>>> rtl/cbta_ctrl.sv
// Controller state machine of the allocator.
module cbta_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  cbta_pkg::dp_stat_t stat,
  input  logic               in_valid,
  input  logic               out_free,
  output logic               in_ready,
  output logic               publish,
  output cbta_pkg::dp_cmd_t  cmd
);

  cbta_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbta_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    publish      = 1'b0;
    cmd          = '0;
    cmd.res_code = cbta_pkg::ST_OK;
    unique case (state)
      cbta_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = cbta_pkg::S_IDLE;
        end
      end
      cbta_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = cbta_pkg::S_DECODE;
        end
      end
      cbta_pkg::S_DECODE: begin
        if (stat.no_card) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = cbta_pkg::ST_NOCARD;
          state_next   = cbta_pkg::S_RESULT;
        end else if (stat.is_free) begin
          state_next = cbta_pkg::S_FREE_STEP;
        end else if (stat.short_space) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = cbta_pkg::ST_INSSPACE;
          state_next   = cbta_pkg::S_RESULT;
        end else begin
          cmd.alloc_begin = 1'b1;
          if (stat.want_zero) begin
            cmd.set_res = 1'b1;
            state_next  = cbta_pkg::S_RESULT;
          end else if (stat.limit_zero) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = cbta_pkg::ST_BROKEN;
            state_next   = cbta_pkg::S_RESULT;
          end else begin
            state_next = cbta_pkg::S_ALLOC_RUN;
          end
        end
      end
      cbta_pkg::S_ALLOC_RUN: begin
        cmd.alloc_step = 1'b1;
        if (stat.alloc_done) begin
          state_next = cbta_pkg::S_TAIL_OK;
        end else if (stat.alloc_broken) begin
          state_next = cbta_pkg::S_TAIL_BAD;
        end
      end
      cbta_pkg::S_TAIL_OK: begin
        cmd.tail_write = 1'b1;
        cmd.tail_ok    = 1'b1;
        cmd.set_res    = 1'b1;
        state_next     = cbta_pkg::S_RESULT;
      end
      cbta_pkg::S_TAIL_BAD: begin
        cmd.tail_write = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_code   = cbta_pkg::ST_BROKEN;
        state_next     = cbta_pkg::S_RESULT;
      end
      cbta_pkg::S_FREE_STEP: begin
        if (stat.walk_end) begin
          cmd.set_res = 1'b1;
          state_next  = cbta_pkg::S_RESULT;
        end else if (stat.walk_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = cbta_pkg::ST_BROKEN;
          state_next   = cbta_pkg::S_RESULT;
        end else begin
          cmd.free_issue = 1'b1;
          state_next     = cbta_pkg::S_FREE_WAIT;
        end
      end
      cbta_pkg::S_FREE_WAIT: begin
        cmd.free_retire = 1'b1;
        state_next      = cbta_pkg::S_FREE_STEP;
      end
      cbta_pkg::S_RESULT: begin
        if (out_free) begin
          publish    = 1'b1;
          state_next = cbta_pkg::S_IDLE;
        end
      end
      default: state_next = cbta_pkg::S_CLEAR;
    endcase
  end

endmodule

>>> rtl/chained_block_table_allocator.sv
// Top level of the chained block table allocator: stream ports, output register, units.
//
//  Channel  | Beat carries                                   | Direction
//  ---------+------------------------------------------------+----------
//  s_*      | one command: allocate a chain or free a chain  | in
//  m_*      | one result for each command                    | out
//  cfg_*    | write of total_blocks or card_present          | in
//
// An allocate probes candidate blocks one at a time (up to the smaller of total_blocks
// and MAX_BLOCKS, minus the reserved blocks), as the link table RAM reads one entry
// per cycle. A free reads each chain link, then clears it; rejected commands and
// empty allocates go from decode straight to the result.
// After reset the table is cleared one entry a cycle, with s_tready low. A stalled
// result holds in the output register; the next command is still taken and waits
// for its result only at the end.
module chained_block_table_allocator #(
  parameter int MAX_BLOCKS      = cbta_pkg::MAX_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = cbta_pkg::RESERVED_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cbta_pkg::S_DATA_W-1:0]     s_tdata,  // alloc_count, chain_start
  input  logic [cbta_pkg::S_USER_W-1:0]     s_tuser,  // cmd
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cbta_pkg::M_DATA_W-1:0]     m_tdata,  // status, first_block,
                                                      // free_count, update_count
  input  logic                              cfg_we,
  input  logic [cbta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbta_pkg::CNT_W-1:0]        cfg_wdata
);

  cbta_pkg::dp_cmd_t            cmd;
  cbta_pkg::dp_stat_t           stat;
  logic                         publish;
  logic                         out_free;
  cbta_pkg::status_t            res_status;
  logic [cbta_pkg::BLK_W-1:0]   res_first;
  logic [cbta_pkg::CNT_W-1:0]   res_free;
  logic [cbta_pkg::UPD_W-1:0]   res_update;

  assign out_free = !m_tvalid || m_tready;

  cbta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .in_ready (s_tready),
    .publish  (publish),
    .cmd      (cmd)
  );

  cbta_datapath #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (cbta_pkg::cmd_t'(s_tuser[0])),
    .in_count   (s_tdata[12:0]),
    .in_start   (s_tdata[28:13]),
    .res_status (res_status),
    .res_first  (res_first),
    .res_free   (res_free),
    .res_update (res_update)
  );

  // Output register: holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      m_tdata <= {1'b0, res_update, res_free, res_first, res_status};
    end
  end

endmodule

>>> rtl/cbta_checker.sv
// Port-level checks of the allocator and their binding to the top level.
module cbta_checker #(
  parameter int RESERVED_BLOCKS = cbta_pkg::RESERVED_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [cbta_pkg::M_DATA_W-1:0] m_tdata
);

  // A stalled result beat stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // The table is being cleared straight after reset, so no command is taken.
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("command taken during table clearing");

  // Commands are handled one at a time.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken back to back");

  // A failed command never reports a chain.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != 2'(cbta_pkg::ST_OK)) |-> m_tdata[17:2] == cbta_pkg::END_MARK)
    else $error("failed command reports a first block");

  // A reported chain never starts in the reserved area.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == 2'(cbta_pkg::ST_OK)) && (m_tdata[17:2] != cbta_pkg::END_MARK)
    |-> m_tdata[17:2] >= cbta_pkg::BLK_W'(RESERVED_BLOCKS))
    else $error("chain starts in a reserved block");

endmodule

bind chained_block_table_allocator cbta_checker #(
  .RESERVED_BLOCKS (RESERVED_BLOCKS)
) u_cbta_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
